FILE: design/sih_pkg.sv
`timescale 1ns / 1ps
package sih_pkg;
   localparam int HASH_W = 32;
   localparam int LEN_W = 13;
   localparam int SYM_W = 16;
   localparam int STATUS_W = 3;
   localparam int SLOT_CFG_W = 13;
   localparam int LIMIT_CFG_W = 17;

   localparam int DEF_POOL_BYTES = 65536;
   localparam int DEF_NUM_SLOTS = 4096;
   localparam int DEF_MAX_LEN = 256;

   localparam logic [STATUS_W-1:0] ST_FOUND = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

   localparam logic CSR_SLOT_COUNT = 1'b0;
   localparam logic CSR_POOL_LIMIT = 1'b1;

   localparam logic REQ_FIND_ONLY = 1'b1;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic              find_only;
      logic              too_long;
      logic [LEN_W-1:0]  len;
   } sih_job_type;
endpackage

FILE: design/string_intern_hash_table_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Beat
// req       in         push / full        one string byte, type, has_byte, last
// rsp       out        empty / pop        symbol, status for each last beat
// csr       in         valid / ready      register index, write data
// A byte is taken each cycle unless full is high; a string end costs a modulo
// and slot read, then a read and a check or write per compared or inserted byte.
// After reset the slot table is cleared slot by slot, with full held high.
// Two strings may queue between front and back; full rises when both wait.
module string_intern_hash_table_core #(
   parameter int POOL_BYTES = sih_pkg::DEF_POOL_BYTES,
   parameter int NUM_SLOTS = sih_pkg::DEF_NUM_SLOTS,
   parameter int MAX_LEN = sih_pkg::DEF_MAX_LEN
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_type,
   input  logic [7:0]                      req_char_byte,
   input  logic                            req_has_byte,
   input  logic                            req_last,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [sih_pkg::SYM_W-1:0]       rsp_symbol,
   output logic [sih_pkg::STATUS_W-1:0]    rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [sih_pkg::LIMIT_CFG_W-1:0] csr_wdata
);
   import sih_pkg::*;

   logic                      clearing, job_pop, job_valid;
   sih_job_type               job_head;
   logic [$clog2(MAX_LEN)-1:0] key_raddr;
   logic [7:0]                key_rdata;

   sih_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_type      (req_type),
      .req_char_byte (req_char_byte),
      .req_has_byte  (req_has_byte),
      .req_last      (req_last),
      .clearing      (clearing),
      .job_pop       (job_pop),
      .job_valid     (job_valid),
      .job_head      (job_head),
      .key_raddr     (key_raddr),
      .key_rdata     (key_rdata)
   );

   sih_back #(
      .POOL_BYTES (POOL_BYTES),
      .NUM_SLOTS  (NUM_SLOTS),
      .MAX_LEN    (MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .clearing   (clearing),
      .job_pop    (job_pop),
      .job_valid  (job_valid),
      .job_head   (job_head),
      .key_raddr  (key_raddr),
      .key_rdata  (key_rdata),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_symbol (rsp_symbol),
      .rsp_status (rsp_status)
   );
endmodule

FILE: design/sih_job_queue.sv
`timescale 1ns / 1ps
module sih_job_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sih_pkg::sih_job_type job_in,
   input  logic                 pop,
   output logic                 full,
   output logic                 valid,
   output sih_pkg::sih_job_type head,
   output logic                 wr_ptr,
   output logic                 rd_ptr
);
   import sih_pkg::*;

   sih_job_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

   assign full = count_ff[1];
   assign valid = (count_ff != 2'd0);
   assign head = entry_ff[rd_ptr_ff];
   assign wr_ptr = wr_ptr_ff;
   assign rd_ptr = rd_ptr_ff;
endmodule

FILE: design/sih_front.sv
`timescale 1ns / 1ps
module sih_front #(
   parameter int MAX_LEN = sih_pkg::DEF_MAX_LEN
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic                       req_type,
   input  logic [7:0]                 req_char_byte,
   input  logic                       req_has_byte,
   input  logic                       req_last,
   input  logic                       clearing,
   input  logic                       job_pop,
   output logic                       job_valid,
   output sih_pkg::sih_job_type       job_head,
   input  logic [$clog2(MAX_LEN)-1:0] key_raddr,
   output logic [7:0]                 key_rdata
);
   import sih_pkg::*;

   localparam int KW = $clog2(MAX_LEN);
   localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LEN);

   logic [7:0]        key_mem [2**(KW+1)];
   logic [7:0]        key_rdata_ff;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              term_ff, term_in;
   logic              accept, take_byte, key_we;
   logic              q_full, wr_ptr, rd_ptr;
   sih_job_type       job;

   assign accept = req_push && !req_full;
   assign take_byte = accept && req_has_byte && !term_ff && (req_char_byte != 8'd0);
   assign key_we = take_byte && (len_ff < MAX_L);

   always_comb begin
      hash_in = hash_ff;
      len_in = len_ff;
      term_in = term_ff;
      if (accept && req_has_byte && !term_ff && (req_char_byte == 8'd0)) begin
         term_in = 1'b1;
      end
      if (take_byte) begin
         hash_in = hash_ff ^ ((hash_ff << 5) + (hash_ff >> 2) + HASH_W'(req_char_byte));
         if (len_ff <= MAX_L) begin
            len_in = len_ff + 1'b1;
         end
      end
      job.hash = hash_in;
      job.find_only = (req_type == REQ_FIND_ONLY);
      job.too_long = (len_in > MAX_L);
      job.len = len_in;
      if (accept && req_last) begin
         hash_in = '0;
         len_in = '0;
         term_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         len_ff <= '0;
         term_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         len_ff <= len_in;
         term_ff <= term_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[{wr_ptr, len_ff[KW-1:0]}] <= req_char_byte;
      end
      key_rdata_ff <= key_mem[{rd_ptr, key_raddr}];
   end

   sih_job_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (accept && req_last),
      .job_in (job),
      .pop    (job_pop),
      .full   (q_full),
      .valid  (job_valid),
      .head   (job_head),
      .wr_ptr (wr_ptr),
      .rd_ptr (rd_ptr)
   );

   assign req_full = q_full || clearing;
   assign key_rdata = key_rdata_ff;
endmodule

FILE: design/sih_back.sv
`timescale 1ns / 1ps
module sih_back #(
   parameter int POOL_BYTES = sih_pkg::DEF_POOL_BYTES,
   parameter int NUM_SLOTS = sih_pkg::DEF_NUM_SLOTS,
   parameter int MAX_LEN = sih_pkg::DEF_MAX_LEN
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [sih_pkg::LIMIT_CFG_W-1:0] csr_wdata,
   output logic                           clearing,
   output logic                           job_pop,
   input  logic                           job_valid,
   input  sih_pkg::sih_job_type           job_head,
   output logic [$clog2(MAX_LEN)-1:0]     key_raddr,
   input  logic [7:0]                     key_rdata,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [sih_pkg::SYM_W-1:0]      rsp_symbol,
   output logic [sih_pkg::STATUS_W-1:0]   rsp_status
);
   import sih_pkg::*;

   localparam int SW = $clog2(NUM_SLOTS + 1);
   localparam int IW = $clog2(NUM_SLOTS);
   localparam int PW = $clog2(POOL_BYTES);
   localparam int UW = $clog2(POOL_BYTES + 1);
   localparam int KW = $clog2(MAX_LEN);

   typedef enum logic [3:0] {
      CLEAR, IDLE, MODULO, SLOT_RD, SLOT_CHK, CMP_RD, CMP_CHK, DECIDE, INS_RD, INS_WR, RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOT_CFG_W-1:0] slot_cfg_ff, slot_cfg_in;
   logic [LIMIT_CFG_W-1:0] limit_cfg_ff, limit_cfg_in;
   logic [SW-1:0]        rem_ff, rem_in;
   logic [4:0]           bit_ff, bit_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        clr_ff, clr_in;
   logic [SW-1:0]        probe_ff, probe_in;
   logic [SYM_W-1:0]     off_ff, off_in;
   logic [LEN_W-1:0]     pos_ff, pos_in;
   logic                 empty_ff, empty_in;
   logic [SW-1:0]        count_ff, count_in;
   logic [UW-1:0]        used_ff, used_in;
   logic [SYM_W-1:0]     sym_ff, sym_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 out_valid_ff, out_valid_in;
   logic [SYM_W-1:0]     out_sym_ff, out_sym_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;

   logic [SYM_W-1:0] slot_mem [NUM_SLOTS];
   logic [SYM_W-1:0] slot_rdata_ff;
   logic             slot_we;
   logic [IW-1:0]    slot_waddr;
   logic [SYM_W-1:0] slot_wdata;
   logic [7:0]       pool_mem [POOL_BYTES];
   logic [7:0]       pool_rdata_ff;
   logic             pool_we;
   logic [PW-1:0]    pool_addr;
   logic [7:0]       pool_wdata;

   logic [31:0]   slots32, limit32, count32, len32, used32;
   logic [SW-1:0] slots;
   logic [SW:0]   div_t;
   logic [SW-1:0] rem_step;
   logic [IW-1:0] idx_next;
   logic          match, at_end, table_full, out_free;

   always_comb begin
      if (slot_cfg_ff == '0) begin
         slots32 = 32'd1;
      end else if (32'(slot_cfg_ff) > NUM_SLOTS) begin
         slots32 = 32'(NUM_SLOTS);
      end else begin
         slots32 = 32'(slot_cfg_ff);
      end
      limit32 = (32'(limit_cfg_ff) > POOL_BYTES) ? 32'(POOL_BYTES) : 32'(limit_cfg_ff);
      slots = slots32[SW-1:0];
      count32 = 32'(count_ff);
      len32 = 32'(job_head.len);
      used32 = 32'(used_ff);
      div_t = {rem_ff, job_head.hash[bit_ff]};
      rem_step = (div_t >= {1'b0, slots}) ? SW'(div_t - {1'b0, slots}) : div_t[SW-1:0];
      idx_next = (32'(idx_ff) + 32'd1 == slots32) ? '0 : idx_ff + 1'b1;
      at_end = (pos_ff == job_head.len);
      match = at_end ? (pool_rdata_ff == 8'd0) : (pool_rdata_ff == key_rdata);
      table_full = !empty_ff || (count32 + 32'd1 >= slots32)
                   || (slots32 < 32'd2 * (count32 + 32'd1))
                   || (used32 + len32 + 32'd1 > limit32);
      out_free = !out_valid_ff || rsp_pop;
   end

   always_comb begin
      state_in = state_ff;
      slot_cfg_in = slot_cfg_ff;
      limit_cfg_in = limit_cfg_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      idx_in = idx_ff;
      clr_in = clr_ff;
      probe_in = probe_ff;
      off_in = off_ff;
      pos_in = pos_ff;
      empty_in = empty_ff;
      count_in = count_ff;
      used_in = used_ff;
      sym_in = sym_ff;
      status_in = status_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_sym_in = out_sym_ff;
      out_status_in = out_status_ff;
      job_pop = 1'b0;
      slot_we = 1'b0;
      slot_waddr = clr_ff;
      slot_wdata = '0;
      pool_we = 1'b0;
      pool_addr = PW'(used32 + 32'(pos_ff));
      pool_wdata = at_end ? 8'd0 : key_rdata;

      if (csr_valid) begin
         if (csr_index == CSR_SLOT_COUNT) begin
            slot_cfg_in = csr_wdata[SLOT_CFG_W-1:0];
         end else begin
            limit_cfg_in = csr_wdata;
         end
      end

      case (state_ff)
         CLEAR: begin
            slot_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == NUM_SLOTS - 1) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (job_valid) begin
               sym_in = '0;
               if (job_head.too_long) begin
                  status_in = ST_TOO_LONG;
                  state_in = RESP;
               end else if (job_head.len == '0) begin
                  status_in = ST_FOUND;
                  state_in = RESP;
               end else begin
                  rem_in = '0;
                  bit_in = 5'd31;
                  state_in = MODULO;
               end
            end
         end
         MODULO: begin
            rem_in = rem_step;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == 5'd0) begin
               idx_in = rem_step[IW-1:0];
               probe_in = '0;
               state_in = SLOT_RD;
            end
         end
         SLOT_RD: begin
            state_in = SLOT_CHK;
         end
         SLOT_CHK: begin
            if (slot_rdata_ff == '0) begin
               empty_in = 1'b1;
               state_in = DECIDE;
            end else begin
               off_in = slot_rdata_ff;
               pos_in = '0;
               state_in = CMP_RD;
            end
         end
         CMP_RD: begin
            pool_addr = PW'(32'(off_ff) + 32'(pos_ff));
            state_in = CMP_CHK;
         end
         CMP_CHK: begin
            if (!match) begin
               probe_in = probe_ff + 1'b1;
               if (32'(probe_ff) + 32'd1 == slots32) begin
                  empty_in = 1'b0;
                  state_in = DECIDE;
               end else begin
                  idx_in = idx_next;
                  state_in = SLOT_RD;
               end
            end else if (at_end) begin
               sym_in = off_ff;
               status_in = ST_FOUND;
               state_in = RESP;
            end else begin
               pos_in = pos_ff + 1'b1;
               state_in = CMP_RD;
            end
         end
         DECIDE: begin
            if (job_head.find_only) begin
               status_in = ST_NOT_FOUND;
               state_in = RESP;
            end else if (table_full) begin
               status_in = ST_FULL;
               state_in = RESP;
            end else begin
               pos_in = '0;
               state_in = INS_RD;
            end
         end
         INS_RD: begin
            state_in = INS_WR;
         end
         INS_WR: begin
            pool_we = 1'b1;
            if (at_end) begin
               slot_we = 1'b1;
               slot_waddr = idx_ff;
               slot_wdata = used_ff[SYM_W-1:0];
               count_in = count_ff + 1'b1;
               used_in = UW'(used32 + len32 + 32'd1);
               sym_in = used_ff[SYM_W-1:0];
               status_in = ST_INSERTED;
               state_in = RESP;
            end else begin
               pos_in = pos_ff + 1'b1;
               state_in = INS_RD;
            end
         end
         RESP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_sym_in = sym_ff;
               out_status_in = status_ff;
               job_pop = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         slot_cfg_ff <= SLOT_CFG_W'(4096);
         limit_cfg_ff <= LIMIT_CFG_W'(65536);
         clr_ff <= '0;
         count_ff <= '0;
         used_ff <= UW'(1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_cfg_ff <= slot_cfg_in;
         limit_cfg_ff <= limit_cfg_in;
         clr_ff <= clr_in;
         count_ff <= count_in;
         used_ff <= used_in;
         out_valid_ff <= out_valid_in;
      end
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      idx_ff <= idx_in;
      probe_ff <= probe_in;
      off_ff <= off_in;
      pos_ff <= pos_in;
      empty_ff <= empty_in;
      sym_ff <= sym_in;
      status_ff <= status_in;
      out_sym_ff <= out_sym_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rdata_ff <= slot_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem[pool_addr] <= pool_wdata;
      end
      pool_rdata_ff <= pool_mem[pool_addr];
   end

   assign csr_ready = 1'b1;
   assign clearing = (state_ff == CLEAR);
   assign key_raddr = pos_ff[KW-1:0];
   assign rsp_empty = !out_valid_ff;
   assign rsp_symbol = out_sym_ff;
   assign rsp_status = out_status_ff;
endmodule
